>>> rtl/pixel_color_matrix_transform_unit_assert.svh
// Assertion macros for the color matrix top level.
`ifndef PIXEL_COLOR_MATRIX_TRANSFORM_UNIT_ASSERT_SVH
`define PIXEL_COLOR_MATRIX_TRANSFORM_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PCMT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PCMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

>>> rtl/pcmt_pkg.sv
`default_nettype none
package pcmt_pkg;

   localparam int PIXEL_FRAC_BITS = 12;
   localparam int COEF_FRAC_BITS  = 14;

   // field widths
   localparam int CH_BITS   = PIXEL_FRAC_BITS + 1;   // unsigned Q1.12, 0 .. just under 2.0
   localparam int COEF_BITS = COEF_FRAC_BITS + 2;    // signed Q2.f
   localparam int OFS_BITS  = PIXEL_FRAC_BITS + 2;   // signed offset
   localparam int NUM_CH    = 3;

   // packed register widths
   localparam int CENTRE_BITS   = NUM_CH * CH_BITS;
   localparam int COEF_ROW_BITS = NUM_CH * COEF_BITS;
   localparam int OFFSET_BITS   = NUM_CH * OFS_BITS;

   // datapath widths
   localparam int DIFF_BITS    = CH_BITS + 1;
   localparam int PRODUCT_BITS = COEF_BITS + DIFF_BITS;
   localparam int SUM_BITS     = PRODUCT_BITS + 2;
   localparam int SHIFT_BITS   = SUM_BITS - COEF_FRAC_BITS;
   localparam int RESULT_BITS  = SHIFT_BITS + 1;

   // stream payload
   localparam int PIXEL_BITS = NUM_CH * CH_BITS;
   localparam int TDATA_BITS = ((PIXEL_BITS + 7) / 8) * 8;

   // CSR map: 64-bit registers at 8-byte spacing
   localparam int NUM_REGS       = 5;
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_ADDR_BITS  = $clog2(8 * NUM_REGS);
   localparam int CSR_INDEX_BITS = CSR_ADDR_BITS - 3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_CENTRE = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_ROW0   = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] REG_ROW1   = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] REG_ROW2   = CSR_INDEX_BITS'(3);
   localparam logic [CSR_INDEX_BITS-1:0] REG_OFFSET = CSR_INDEX_BITS'(4);

   localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1 << COEF_FRAC_BITS);
   localparam logic [CH_BITS-1:0]   PIXEL_TOP = CH_BITS'(1 << PIXEL_FRAC_BITS);

   typedef logic [CH_BITS-1:0] pixel_ch_type;
   typedef logic signed [DIFF_BITS-1:0] diff_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic [CENTRE_BITS-1:0]               centre;
      logic [NUM_CH-1:0][COEF_ROW_BITS-1:0] rows;
      logic [OFFSET_BITS-1:0]               offset;
   } cfg_type;

endpackage
`default_nettype wire

>>> rtl/pixel_color_matrix_transform_unit.sv
`default_nettype none
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  tdata: red, green, blue (13 b each)
// rsp_      out        rsp_tvalid/rsp_tready  tdata: red, green, blue (13 b each)
// csr_      in (APB)   psel/penable/pready    5 x 64-bit registers at 8-byte steps
//
// Cycles: a request is registered at the input stage, goes through one pass of
// centre subtract, 3x3 multiply (nine 16x14 multipliers), round, offset and
// clamp, and lands in the result register; 1 request/cycle unless the output stalls.
// Reset: synchronous, active high; clears both stage valids and loads the
// identity matrix, zero centre and zero offset.
// Stalls: the input stage stays ready while the result register drains, so a
// held rsp_tready costs throughput only once both stages are full.
module pixel_color_matrix_transform_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request stream
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // [12:0] in_red, [25:13] in_green, [38:26] in_blue, [39] zero
   input  wire logic [pcmt_pkg::TDATA_BITS-1:0]       req_tdata,
   // result stream
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // [12:0] out_red, [25:13] out_green, [38:26] out_blue, [39] zero
   output logic      [pcmt_pkg::TDATA_BITS-1:0]       rsp_tdata,
   // configuration port
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [pcmt_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  wire logic [pcmt_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic      [pcmt_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                       csr_pready
);

   pcmt_pkg::cfg_type cfg;

   // input stage
   logic                                 stage_valid_ff, stage_valid_in;
   logic [pcmt_pkg::PIXEL_BITS-1:0]      stage_pixel_ff, stage_pixel_in;
   // result stage
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [pcmt_pkg::PIXEL_BITS-1:0]      rsp_pixel_ff, rsp_pixel_in;

   logic                                 advance;
   pcmt_pkg::diff_type [pcmt_pkg::NUM_CH-1:0] diff;
   pcmt_pkg::pixel_ch_type               result [pcmt_pkg::NUM_CH];

   pcmt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // result register frees when empty or being taken
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !stage_valid_ff || advance;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_pixel_in = stage_pixel_ff;
      if (req_tready) begin
         stage_valid_in = req_tvalid;
         stage_pixel_in = req_tdata[pcmt_pkg::PIXEL_BITS-1:0];
      end
   end

   // signed distance from the configured centre, per channel
   always_comb begin
      for (int c = 0; c < pcmt_pkg::NUM_CH; c++) begin
         diff[c] = signed'(pcmt_pkg::DIFF_BITS'(
                      stage_pixel_ff[c*pcmt_pkg::CH_BITS +: pcmt_pkg::CH_BITS]))
                 - signed'(pcmt_pkg::DIFF_BITS'(
                      cfg.centre[c*pcmt_pkg::CH_BITS +: pcmt_pkg::CH_BITS]));
      end
   end

   for (genvar r = 0; r < pcmt_pkg::NUM_CH; r++) begin : g_row
      pcmt_row u_row (
         .coef_row (cfg.rows[r]),
         .diff     (diff),
         .offset   (cfg.offset[r*pcmt_pkg::OFS_BITS +: pcmt_pkg::OFS_BITS]),
         .result   (result[r])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pixel_in = rsp_pixel_ff;
      if (advance) begin
         rsp_valid_in = stage_valid_ff;
         rsp_pixel_in = {result[2], result[1], result[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      stage_pixel_ff <= stage_pixel_in;
      rsp_pixel_ff   <= rsp_pixel_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = pcmt_pkg::TDATA_BITS'(rsp_pixel_ff);

`include "pixel_color_matrix_transform_unit_assert.svh"

   // a request never lands while both stages are full and the output is stuck
   `PCMT_ASSERT_IMPLY(a_no_overrun, clock, reset, req_tvalid && req_tready, !stage_valid_ff || !rsp_valid_ff || rsp_tready)

   // a held input-stage request is not dropped
   `PCMT_ASSERT_NEXT(a_stage_holds, clock, reset, stage_valid_ff && !advance, stage_valid_ff && $stable(stage_pixel_ff))

   // a moving input-stage request shows up as a result next cycle
   `PCMT_ASSERT_NEXT(a_stage_to_rsp, clock, reset, stage_valid_ff && advance, rsp_tvalid)

   // every channel is saturated to the 1.0 ceiling
   `PCMT_ASSERT_IMPLY(a_clamped, clock, reset, rsp_tvalid, (rsp_pixel_ff[12:0] <= pcmt_pkg::PIXEL_TOP) && (rsp_pixel_ff[25:13] <= pcmt_pkg::PIXEL_TOP) && (rsp_pixel_ff[38:26] <= pcmt_pkg::PIXEL_TOP))

endmodule
`default_nettype wire

>>> rtl/pcmt_csr.sv
`default_nettype none
module pcmt_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [pcmt_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  wire logic [pcmt_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic      [pcmt_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                       csr_pready,
   output pcmt_pkg::cfg_type                          cfg
);

   logic [pcmt_pkg::CENTRE_BITS-1:0]   centre_ff, centre_in;
   logic [pcmt_pkg::COEF_ROW_BITS-1:0] row0_ff, row0_in;
   logic [pcmt_pkg::COEF_ROW_BITS-1:0] row1_ff, row1_in;
   logic [pcmt_pkg::COEF_ROW_BITS-1:0] row2_ff, row2_in;
   logic [pcmt_pkg::OFFSET_BITS-1:0]   offset_ff, offset_in;
   logic [pcmt_pkg::CSR_INDEX_BITS-1:0] index;
   logic                                write_en;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[pcmt_pkg::CSR_ADDR_BITS-1:3];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      centre_in = centre_ff;
      row0_in   = row0_ff;
      row1_in   = row1_ff;
      row2_in   = row2_ff;
      offset_in = offset_ff;
      if (write_en) begin
         case (index)
            pcmt_pkg::REG_CENTRE: begin
               centre_in = csr_pwdata[pcmt_pkg::CENTRE_BITS-1:0];
            end
            pcmt_pkg::REG_ROW0: begin
               row0_in = csr_pwdata[pcmt_pkg::COEF_ROW_BITS-1:0];
            end
            pcmt_pkg::REG_ROW1: begin
               row1_in = csr_pwdata[pcmt_pkg::COEF_ROW_BITS-1:0];
            end
            pcmt_pkg::REG_ROW2: begin
               row2_in = csr_pwdata[pcmt_pkg::COEF_ROW_BITS-1:0];
            end
            pcmt_pkg::REG_OFFSET: begin
               offset_in = csr_pwdata[pcmt_pkg::OFFSET_BITS-1:0];
            end
            default: begin
               // unmapped: write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_ff <= '0;
         // identity matrix
         row0_ff   <= pcmt_pkg::COEF_ROW_BITS'(pcmt_pkg::COEF_ONE);
         row1_ff   <= pcmt_pkg::COEF_ROW_BITS'(pcmt_pkg::COEF_ONE) << pcmt_pkg::COEF_BITS;
         row2_ff   <= pcmt_pkg::COEF_ROW_BITS'(pcmt_pkg::COEF_ONE)
                      << (2 * pcmt_pkg::COEF_BITS);
         offset_ff <= '0;
      end else begin
         centre_ff <= centre_in;
         row0_ff   <= row0_in;
         row1_ff   <= row1_in;
         row2_ff   <= row2_in;
         offset_ff <= offset_in;
      end
   end

   always_comb begin
      case (index)
         pcmt_pkg::REG_CENTRE: csr_prdata = pcmt_pkg::CSR_DATA_BITS'(centre_ff);
         pcmt_pkg::REG_ROW0:   csr_prdata = pcmt_pkg::CSR_DATA_BITS'(row0_ff);
         pcmt_pkg::REG_ROW1:   csr_prdata = pcmt_pkg::CSR_DATA_BITS'(row1_ff);
         pcmt_pkg::REG_ROW2:   csr_prdata = pcmt_pkg::CSR_DATA_BITS'(row2_ff);
         pcmt_pkg::REG_OFFSET: csr_prdata = pcmt_pkg::CSR_DATA_BITS'(offset_ff);
         default:              csr_prdata = '0;
      endcase
   end

   assign cfg.centre  = centre_ff;
   assign cfg.rows[0] = row0_ff;
   assign cfg.rows[1] = row1_ff;
   assign cfg.rows[2] = row2_ff;
   assign cfg.offset  = offset_ff;

endmodule
`default_nettype wire

>>> rtl/pcmt_row.sv
`default_nettype none
// One output channel: dot product, round, offset, saturate.
module pcmt_row (
   input  wire logic [pcmt_pkg::COEF_ROW_BITS-1:0]             coef_row,
   input  wire pcmt_pkg::diff_type [pcmt_pkg::NUM_CH-1:0]      diff,
   input  wire logic [pcmt_pkg::OFS_BITS-1:0]                  offset,
   output pcmt_pkg::pixel_ch_type                              result
);

   localparam logic signed [pcmt_pkg::SUM_BITS-1:0] HALF_LSB =
      pcmt_pkg::SUM_BITS'(1 << (pcmt_pkg::COEF_FRAC_BITS - 1));

   logic signed [pcmt_pkg::PRODUCT_BITS-1:0] prod [pcmt_pkg::NUM_CH];
   logic signed [pcmt_pkg::SUM_BITS-1:0]     sum;
   logic signed [pcmt_pkg::SUM_BITS-1:0]     biased;
   logic signed [pcmt_pkg::SHIFT_BITS-1:0]   shifted;
   logic signed [pcmt_pkg::OFS_BITS-1:0]     offset_s;
   logic signed [pcmt_pkg::RESULT_BITS-1:0]  value;

   always_comb begin
      for (int c = 0; c < pcmt_pkg::NUM_CH; c++) begin
         prod[c] = pcmt_pkg::PRODUCT_BITS'(
                      signed'(coef_row[c*pcmt_pkg::COEF_BITS +: pcmt_pkg::COEF_BITS]))
                   * pcmt_pkg::PRODUCT_BITS'(diff[c]);
      end
   end

   assign sum = pcmt_pkg::SUM_BITS'(prod[0]) + pcmt_pkg::SUM_BITS'(prod[1])
              + pcmt_pkg::SUM_BITS'(prod[2]);

   // round half up: floor((s + half) / 2^f)
   assign biased   = sum + HALF_LSB;
   assign shifted  = signed'(biased[pcmt_pkg::SUM_BITS-1:pcmt_pkg::COEF_FRAC_BITS]);
   assign offset_s = signed'(offset);
   assign value    = pcmt_pkg::RESULT_BITS'(shifted) + pcmt_pkg::RESULT_BITS'(offset_s);

   always_comb begin
      if (value < 0) begin
         result = '0;
      end else if (value > signed'(pcmt_pkg::RESULT_BITS'(pcmt_pkg::PIXEL_TOP))) begin
         result = pcmt_pkg::PIXEL_TOP;
      end else begin
         result = value[pcmt_pkg::CH_BITS-1:0];
      end
   end

endmodule
`default_nettype wire

>>> bench/pixel_color_matrix_transform_unit_tb.sv
`default_nettype none
module pixel_color_matrix_transform_unit_tb;
   // Self-checking bench for the 3x3 color correction matrix.
   // Requests go in on req_, transformed pixels come back on rsp_, and the
   // matrix, centre and offset registers are loaded over the APB-style csr_ port.
   // Each accepted request queues the hand-computed result from the directed
   // table if it has one, else a pixel predicted by a local model of the datapath
   // (centre subtract, signed multiply, round half up, offset, clamp); each
   // accepted result is checked against the oldest queued pixel, channel by channel.
   import pcmt_pkg::*;

   localparam int STALL_LIMIT = 2000;   // cycles with no handshake at all
   localparam int SETTLE_CYCLES = 4;    // pipeline is 2 deep, leave margin
   localparam int PHASES = 8;
   localparam int PHASE_REQUESTS = 250;

   // index past the end of the register map, writes must be dropped
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNMAPPED = CSR_INDEX_BITS'(NUM_REGS);

   typedef enum logic {STEP_CONFIG, STEP_PIXEL} step_kind_type;

   // one row of the directed table: either a register write or a request,
   // the latter optionally with a hand-computed result
   typedef struct {
      step_kind_type             kind;
      logic [CSR_INDEX_BITS-1:0] reg_index;
      logic [CSR_DATA_BITS-1:0]  value;
      logic [PIXEL_BITS-1:0]     pixel;
      bit                        has_result;
      logic [PIXEL_BITS-1:0]     result;
   } plan_step_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   // [12:0] in_red, [25:13] in_green, [38:26] in_blue, [39] zero
   logic [TDATA_BITS-1:0]      req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   // [12:0] out_red, [25:13] out_green, [38:26] out_blue, [39] zero
   logic [TDATA_BITS-1:0]      rsp_tdata;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]   csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0]   csr_prdata;
   logic                       csr_pready;

   // local copy of the register file
   logic [CENTRE_BITS-1:0]     centre_reg = '0;
   logic [COEF_ROW_BITS-1:0]   row_reg [NUM_CH];
   logic [OFFSET_BITS-1:0]     offset_reg = '0;

   logic [PIXEL_BITS-1:0]      pending_pixels [$];
   bit                         typed_pending = 1'b0;
   logic [PIXEL_BITS-1:0]      typed_result = '0;
   int                         mismatch_count = 0;
   int                         idle_cycles = 0;
   int                         send_idle_pct = 0;
   int                         recv_idle_pct = 0;
   string                      channel_name [NUM_CH] = '{"red", "green", "blue"};

   plan_step_type              plan [$];

   pixel_color_matrix_transform_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   initial begin
      for (int r = 0; r < NUM_CH; r++) begin
         row_reg[r] = COEF_ROW_BITS'(COEF_ONE) << (r * COEF_BITS);
      end
   end

   // ---------------------------------------------------------------------
   // packing helpers, red always in the lowest bits
   // ---------------------------------------------------------------------
   function automatic logic [PIXEL_BITS-1:0] rgb(input int red, input int green,
                                                 input int blue);
      return {CH_BITS'(blue), CH_BITS'(green), CH_BITS'(red)};
   endfunction

   function automatic logic [COEF_ROW_BITS-1:0] coefs(input int c0, input int c1,
                                                      input int c2);
      return {COEF_BITS'(c2), COEF_BITS'(c1), COEF_BITS'(c0)};
   endfunction

   function automatic logic [OFFSET_BITS-1:0] offsets(input int red, input int green,
                                                      input int blue);
      return {OFS_BITS'(blue), OFS_BITS'(green), OFS_BITS'(red)};
   endfunction

   function automatic plan_step_type config_step(input logic [CSR_INDEX_BITS-1:0] idx,
                                                 input logic [CSR_DATA_BITS-1:0] value);
      plan_step_type s;
      s = '{STEP_CONFIG, idx, value, '0, 1'b0, '0};
      return s;
   endfunction

   function automatic plan_step_type pixel_step(input logic [PIXEL_BITS-1:0] pixel,
                                                input bit has_result,
                                                input logic [PIXEL_BITS-1:0] result);
      plan_step_type s;
      s = '{STEP_PIXEL, '0, '0, pixel, has_result, result};
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // datapath model: exact integer math, round half toward +inf, clamp
   // ---------------------------------------------------------------------
   function automatic logic [PIXEL_BITS-1:0] transform_pixel(
         input logic [PIXEL_BITS-1:0] pixel);
      longint diff [NUM_CH];
      longint acc;
      longint v;
      logic [PIXEL_BITS-1:0] res;
      res = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         diff[c] = longint'(pixel[c*CH_BITS +: CH_BITS])
                 - longint'(centre_reg[c*CH_BITS +: CH_BITS]);
      end
      for (int r = 0; r < NUM_CH; r++) begin
         acc = 0;
         for (int c = 0; c < NUM_CH; c++) begin
            acc += longint'($signed(row_reg[r][c*COEF_BITS +: COEF_BITS])) * diff[c];
         end
         // arithmetic shift floors, so adding half first rounds halves up
         v = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
         v += longint'($signed(offset_reg[r*OFS_BITS +: OFS_BITS]));
         if (v < 0) begin
            v = 0;
         end
         if (v > longint'(PIXEL_TOP)) begin
            v = longint'(PIXEL_TOP);
         end
         res[r*CH_BITS +: CH_BITS] = v[CH_BITS-1:0];
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // random content
   // ---------------------------------------------------------------------
   function automatic int rand_channel();
      int k;
      k = $urandom_range(0, 9);
      if (k < 8) begin
         return $urandom_range(0, 4096);
      end else if (k == 8) begin
         return $urandom_range(0, 8191);   // full 13-bit range, above 1.0 still legal
      end
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 4096;
         default: return 8191;
      endcase
   endfunction

   // mode 0: near identity, 1: any bits, 2: moderate, 3: extremes
   function automatic int rand_coef(input int mode, input bit diag);
      case (mode)
         0: return (diag ? 16384 : 0) + int'($urandom_range(0, 4096)) - 2048;
         1: return int'($urandom_range(0, 65535)) - 32768;
         2: return int'($urandom_range(0, 32767)) - 16384;
         default: begin
            case ($urandom_range(0, 3))
               0: return -32768;
               1: return 32767;
               2: return 0;
               default: return 16384;
            endcase
         end
      endcase
   endfunction

   function automatic int rand_centre(input int mode);
      case (mode)
         0: return $urandom_range(0, 256);
         1: return $urandom_range(0, 8191);
         2: return $urandom_range(0, 4096);
         default: begin
            case ($urandom_range(0, 3))
               0: return 0;
               1: return 8191;
               2: return 4096;
               default: return 2048;
            endcase
         end
      endcase
   endfunction

   function automatic int rand_offset(input int mode);
      case (mode)
         0: return int'($urandom_range(0, 512)) - 256;
         1: return int'($urandom_range(0, 16383)) - 8192;
         2: return int'($urandom_range(0, 4095)) - 2048;
         default: begin
            case ($urandom_range(0, 3))
               0: return -8192;
               1: return 8191;
               2: return 0;
               default: return -1;
            endcase
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // drivers, all called at a falling edge and returning at one
   // ---------------------------------------------------------------------
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_CENTRE: centre_reg = value[CENTRE_BITS-1:0];
         REG_ROW0:   row_reg[0] = value[COEF_ROW_BITS-1:0];
         REG_ROW1:   row_reg[1] = value[COEF_ROW_BITS-1:0];
         REG_ROW2:   row_reg[2] = value[COEF_ROW_BITS-1:0];
         REG_OFFSET: offset_reg = value[OFFSET_BITS-1:0];
         default: ;   // unmapped, dropped
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // leave the bus idle, so a following write starts on a fresh edge
      @(negedge clock);
   endtask

   // hold requests off until every result is back and the pipe is empty
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic push_pixel(input logic [PIXEL_BITS-1:0] pixel);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= TDATA_BITS'(pixel);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic load_random_config(input int mode);
      write_reg(REG_CENTRE, CSR_DATA_BITS'(rgb(rand_centre(mode), rand_centre(mode),
                                               rand_centre(mode))));
      write_reg(REG_ROW0, CSR_DATA_BITS'(coefs(rand_coef(mode, 1'b1),
                                               rand_coef(mode, 1'b0),
                                               rand_coef(mode, 1'b0))));
      write_reg(REG_ROW1, CSR_DATA_BITS'(coefs(rand_coef(mode, 1'b0),
                                               rand_coef(mode, 1'b1),
                                               rand_coef(mode, 1'b0))));
      write_reg(REG_ROW2, CSR_DATA_BITS'(coefs(rand_coef(mode, 1'b0),
                                               rand_coef(mode, 1'b0),
                                               rand_coef(mode, 1'b1))));
      write_reg(REG_OFFSET, CSR_DATA_BITS'(offsets(rand_offset(mode), rand_offset(mode),
                                                   rand_offset(mode))));
   endtask

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------------
   // monitor: check results first, then queue the prediction for a new
   // request, so a result passed straight through with its own request
   // could never be matched against it
   always @(posedge clock) begin
      logic [PIXEL_BITS-1:0] want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_pixels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("result %h with no request pending", rsp_tdata);
               end
            end else begin
               want = pending_pixels.pop_front();
               for (int c = 0; c < NUM_CH; c++) begin
                  if (rsp_tdata[c*CH_BITS +: CH_BITS] != want[c*CH_BITS +: CH_BITS]) begin
                     mismatch_count++;
                     if (mismatch_count <= 10) begin
                        $display("%s mismatch: expected %0d, got %0d", channel_name[c],
                                 want[c*CH_BITS +: CH_BITS],
                                 rsp_tdata[c*CH_BITS +: CH_BITS]);
                     end
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pending_pixels.push_back(typed_pending ? typed_result
                                                   : transform_pixel(req_tdata[PIXEL_BITS-1:0]));
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // watchdog
   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      // directed table; the config in force is noted before each group
      // reset: identity, zero centre, zero offset
      plan.push_back(pixel_step(rgb(0, 0, 0), 1'b1, rgb(0, 0, 0)));
      plan.push_back(pixel_step(rgb(4096, 4096, 4096), 1'b1, rgb(4096, 4096, 4096)));
      plan.push_back(pixel_step(rgb(8191, 8191, 8191), 1'b1, rgb(4096, 4096, 4096)));
      plan.push_back(pixel_step(rgb(1, 2, 3), 1'b1, rgb(1, 2, 3)));
      plan.push_back(pixel_step(rgb(4097, 0, 4095), 1'b1, rgb(4096, 0, 4095)));
      // centre above the input gives a negative difference
      plan.push_back(config_step(REG_CENTRE, CSR_DATA_BITS'(rgb(2, 0, 8191))));
      plan.push_back(pixel_step(rgb(1, 5, 8191), 1'b1, rgb(0, 5, 0)));
      // offsets at both ends of their range
      plan.push_back(config_step(REG_OFFSET, CSR_DATA_BITS'(offsets(8191, -8192, 0))));
      plan.push_back(pixel_step(rgb(0, 4096, 8191), 1'b1, rgb(4096, 0, 0)));
      // write past the map must not disturb anything
      plan.push_back(config_step(REG_UNMAPPED, '1));
      plan.push_back(pixel_step(rgb(0, 4096, 8191), 1'b1, rgb(4096, 0, 0)));
      // halves: 0.5 coefficient, +0.5 and -0.5 both round up
      plan.push_back(config_step(REG_CENTRE, '0));
      plan.push_back(config_step(REG_OFFSET, '0));
      plan.push_back(config_step(REG_ROW0, CSR_DATA_BITS'(coefs(8192, 0, 0))));
      plan.push_back(pixel_step(rgb(1, 0, 0), 1'b1, rgb(1, 0, 0)));
      plan.push_back(pixel_step(rgb(3, 7, 9), 1'b1, rgb(2, 7, 9)));
      plan.push_back(config_step(REG_CENTRE, CSR_DATA_BITS'(rgb(2, 0, 0))));
      plan.push_back(pixel_step(rgb(1, 7, 9), 1'b1, rgb(0, 7, 9)));
      plan.push_back(pixel_step(rgb(0, 7, 9), 1'b0, '0));
      // extreme coefficients
      plan.push_back(config_step(REG_CENTRE, '0));
      plan.push_back(config_step(REG_ROW0, CSR_DATA_BITS'(coefs(-32768, -32768, -32768))));
      plan.push_back(config_step(REG_ROW1, CSR_DATA_BITS'(coefs(32767, 32767, 32767))));
      plan.push_back(config_step(REG_ROW2, '0));
      plan.push_back(pixel_step(rgb(4096, 4096, 4096), 1'b1, rgb(0, 4096, 0)));
      plan.push_back(config_step(REG_CENTRE, CSR_DATA_BITS'(rgb(8191, 8191, 8191))));
      plan.push_back(pixel_step(rgb(0, 0, 0), 1'b1, rgb(4096, 0, 0)));
      plan.push_back(config_step(REG_OFFSET, CSR_DATA_BITS'(offsets(-1, 8191, 4096))));
      plan.push_back(pixel_step(rgb(8191, 8191, 8191), 1'b1, rgb(0, 4096, 4096)));
      plan.push_back(pixel_step(rgb(1234, 77, 4000), 1'b0, '0));
      plan.push_back(pixel_step(rgb(8191, 0, 4096), 1'b0, '0));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 35;
      recv_idle_pct = 85;
      foreach (plan[i]) begin
         if (plan[i].kind == STEP_CONFIG) begin
            drain_pipeline();
            write_reg(plan[i].reg_index, plan[i].value);
         end else begin
            typed_pending = plan[i].has_result;
            typed_result  = plan[i].result;
            push_pixel(plan[i].pixel);
         end
      end
      typed_pending = 1'b0;

      // random phases: a fresh register set each, idling pattern by phase
      for (int p = 0; p < PHASES; p++) begin
         drain_pipeline();
         if (p < 3) begin
            send_idle_pct = 35;
            recv_idle_pct = 85;
         end else if (p < 6) begin
            send_idle_pct = 85;
            recv_idle_pct = 35;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         load_random_config(p % 4);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (p == 1 && n == PHASE_REQUESTS / 2) begin
               drain_pipeline();   // let the pipe run dry mid-stream
            end
            push_pixel(rgb(rand_channel(), rand_channel(), rand_channel()));
         end
      end

      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (2 * SETTLE_CYCLES) @(negedge clock);   // catch stray results
      if (mismatch_count == 0 && pending_pixels.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/pcmt_pkg.sv
rtl/pcmt_csr.sv
rtl/pcmt_row.sv
rtl/pixel_color_matrix_transform_unit.sv
bench/pixel_color_matrix_transform_unit_tb.sv
